// File: rtl/core/bhpq_pkg.sv
package bhpq_pkg;

	localparam int DEF_DEPTH     = 64;
	localparam int DEF_KEY_WIDTH = 32;
	localparam int DEF_TAG_WIDTH = 16;

	localparam int OP_W   = 2;
	localparam int STAT_W = 2;
	localparam int CAP_W  = 7;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

	typedef enum logic [OP_W-1:0] {
		OP_INSERT  = 2'd0,
		OP_EXTRACT = 2'd1,
		OP_PEEK    = 2'd2
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_UP_CMP  = 7'b0000010,
		S_TOP_CAP = 7'b0000100,
		S_DN_SEL  = 7'b0001000,
		S_DN_CMP  = 7'b0010000,
		S_PLACE   = 7'b0100000,
		S_FIN     = 7'b1000000
	} state_t;

endpackage

// File: rtl/core/bhpq_store.sv
module bhpq_store #(
	parameter int DEPTH = bhpq_pkg::DEF_DEPTH,
	parameter int WIDTH = bhpq_pkg::DEF_KEY_WIDTH + bhpq_pkg::DEF_TAG_WIDTH
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// File: rtl/core/binary_heap_priority_queue.sv
// Max-heap priority queue, one transaction at a time through a shared key comparator.
// From accept to result valid: insert reads one parent per level climbed (an empty heap
// is written at once); extract reads root and last entry, then selects and compares per
// level descended; peek reads the root; reject, empty take and unused opcode go to the
// result, held while the output stalls; next accepted the cycle after it is registered.
// Reset clears the count and restores capacity 64; heap memory is not cleared.
module binary_heap_priority_queue #(
	parameter int DEPTH     = bhpq_pkg::DEF_DEPTH,
	parameter int KEY_WIDTH = bhpq_pkg::DEF_KEY_WIDTH,
	parameter int TAG_WIDTH = bhpq_pkg::DEF_TAG_WIDTH
) (
	input  logic clk,
	input  logic arst_n,

	input  logic                                       s_tvalid,
	output logic                                       s_tready,
	// key, tag
	input  logic [((KEY_WIDTH+TAG_WIDTH+7)/8)*8-1:0]   s_tdata,
	// opcode
	input  logic [bhpq_pkg::OP_W-1:0]                  s_tuser,

	output logic                                       m_tvalid,
	input  logic                                       m_tready,
	// out_key, out_tag, entry_count_out, is_empty
	output logic [((KEY_WIDTH+TAG_WIDTH+$clog2(DEPTH+1)+1+7)/8)*8-1:0] m_tdata,
	// status
	output logic [bhpq_pkg::STAT_W-1:0]                m_tuser,

	input  logic                                       cfg_valid,
	output logic                                       cfg_ready,
	input  logic [bhpq_pkg::CAP_W-1:0]                 cfg_data
);

	import bhpq_pkg::*;

	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int EW    = KEY_WIDTH + TAG_WIDTH;
	localparam int CMPW  = (CW > CAP_W) ? CW : CAP_W;
	localparam int OUT_W = ((KEY_WIDTH + TAG_WIDTH + CW + 1 + 7) / 8) * 8;

	state_t               state_q, state_d;
	logic [CW-1:0]        count_q;
	logic [CAP_W-1:0]     cap_q;
	logic                 m_tvalid_q;

	logic [EW-1:0]        item_q, child_q;
	logic [AW-1:0]        hole_q, child_idx_q;
	logic [CW-1:0]        len_q;
	logic                 peek_q;
	logic [KEY_WIDTH-1:0] res_key_q, m_key_q;
	logic [TAG_WIDTH-1:0] res_tag_q, m_tag_q;
	status_t              res_stat_q, m_stat_q;
	logic [CW-1:0]        m_cnt_q;
	logic                 m_empty_q;

	logic                 we;
	logic [AW-1:0]        waddr, raddr_a, raddr_b;
	logic [EW-1:0]        wdata, rd_a, rd_b;

	logic [KEY_WIDTH-1:0] key_in, cmp_a, cmp_b;
	logic [TAG_WIDTH-1:0] tag_in;
	logic                 lt, accept, full, count_zero, ins_ok, take_ok, ext_ok, out_load;
	logic                 right_ok;
	status_t              stat_in;
	logic [AW-1:0]        cnt_a, cnt_m1, par_cnt, par_hole, par_par;
	logic [AW:0]          c_hole, c_child, len_x;

	bhpq_store #(
		.DEPTH (DEPTH),
		.WIDTH (EW)
	) u_store (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	assign key_in = s_tdata[KEY_WIDTH-1:0];
	assign tag_in = s_tdata[EW-1:KEY_WIDTH];

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;

	assign count_zero = (count_q == '0);
	assign full       = (CMPW'(count_q) >= CMPW'(cap_q)) || (CMPW'(count_q) >= CMPW'(DEPTH));
	assign ins_ok     = accept && (s_tuser == OP_INSERT) && !full;
	assign take_ok    = accept && ((s_tuser == OP_EXTRACT) || (s_tuser == OP_PEEK)) && !count_zero;
	assign ext_ok     = take_ok && (s_tuser == OP_EXTRACT);
	assign out_load   = (state_q == S_FIN) && (!m_tvalid_q || m_tready);

	assign cnt_a    = AW'(count_q);
	assign cnt_m1   = AW'(count_q - CW'(1));
	assign par_cnt  = (cnt_a - AW'(1)) >> 1;
	assign par_hole = (hole_q - AW'(1)) >> 1;
	assign par_par  = (par_hole - AW'(1)) >> 1;
	assign c_hole   = {hole_q, 1'b1};
	assign c_child  = {child_idx_q, 1'b1};
	assign len_x    = (AW+1)'(len_q);
	assign right_ok = (c_hole + (AW+1)'(1)) < len_x;

	always_comb begin
		stat_in = ST_OK;
		case (s_tuser) inside
			OP_INSERT: begin
				if (full) begin
					stat_in = ST_FULL;
				end
			end
			OP_EXTRACT, OP_PEEK: begin
				if (count_zero) begin
					stat_in = ST_EMPTY;
				end
			end
			default: stat_in = ST_OK;
		endcase
	end

	// shared comparator: cmp_a < cmp_b
	always_comb begin
		cmp_a = '0;
		cmp_b = '0;
		case (state_q)
			S_UP_CMP: begin
				cmp_a = rd_a[EW-1:TAG_WIDTH];
				cmp_b = item_q[EW-1:TAG_WIDTH];
			end
			S_DN_SEL: begin
				cmp_a = rd_a[EW-1:TAG_WIDTH];
				cmp_b = rd_b[EW-1:TAG_WIDTH];
			end
			S_DN_CMP: begin
				cmp_a = item_q[EW-1:TAG_WIDTH];
				cmp_b = child_q[EW-1:TAG_WIDTH];
			end
			default: ;
		endcase
		lt = cmp_a < cmp_b;
	end

	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = hole_q;
		wdata   = item_q;
		raddr_a = '0;
		raddr_b = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_FIN;
					if (ins_ok) begin
						if (count_zero) begin
							we    = 1'b1;
							waddr = '0;
							wdata = {key_in, tag_in};
						end else begin
							raddr_a = par_cnt;
							state_d = S_UP_CMP;
						end
					end else if (take_ok) begin
						raddr_b = cnt_m1;
						state_d = S_TOP_CAP;
					end
				end
			end
			S_UP_CMP: begin
				we = 1'b1;
				if (lt) begin
					wdata   = rd_a;
					raddr_a = par_par;
					state_d = (par_hole == '0) ? S_PLACE : S_UP_CMP;
				end else begin
					state_d = S_FIN;
				end
			end
			S_TOP_CAP: begin
				raddr_a = AW'(1);
				raddr_b = AW'(2);
				if (peek_q) begin
					state_d = S_FIN;
				end else begin
					state_d = (len_x > (AW+1)'(1)) ? S_DN_SEL : S_PLACE;
				end
			end
			S_DN_SEL: begin
				state_d = S_DN_CMP;
			end
			S_DN_CMP: begin
				we = 1'b1;
				if (lt) begin
					wdata   = child_q;
					raddr_a = c_child[AW-1:0];
					raddr_b = c_child[AW-1:0] + AW'(1);
					state_d = (c_child < len_x) ? S_DN_SEL : S_PLACE;
				end else begin
					state_d = S_FIN;
				end
			end
			S_PLACE: begin
				we      = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			cap_q      <= CAP_RESET;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
			if (ins_ok) begin
				count_q <= count_q + CW'(1);
			end else if (ext_ok) begin
				count_q <= count_q - CW'(1);
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					item_q     <= {key_in, tag_in};
					peek_q     <= (s_tuser == OP_PEEK);
					hole_q     <= cnt_a;
					len_q      <= count_q - CW'(1);
					res_key_q  <= '0;
					res_tag_q  <= '0;
					res_stat_q <= stat_in;
				end
			end
			S_UP_CMP: begin
				if (lt) begin
					hole_q <= par_hole;
				end
			end
			S_TOP_CAP: begin
				res_key_q <= rd_a[EW-1:TAG_WIDTH];
				res_tag_q <= rd_a[TAG_WIDTH-1:0];
				item_q    <= rd_b;
				hole_q    <= '0;
			end
			S_DN_SEL: begin
				if (right_ok && lt) begin
					child_q     <= rd_b;
					child_idx_q <= c_hole[AW-1:0] + AW'(1);
				end else begin
					child_q     <= rd_a;
					child_idx_q <= c_hole[AW-1:0];
				end
			end
			S_DN_CMP: begin
				if (lt) begin
					hole_q <= child_idx_q;
				end
			end
			S_FIN: begin
				if (out_load) begin
					m_key_q   <= res_key_q;
					m_tag_q   <= res_tag_q;
					m_stat_q  <= res_stat_q;
					m_cnt_q   <= count_q;
					m_empty_q <= count_zero;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_W'({m_empty_q, m_cnt_q, m_tag_q, m_key_q});
	assign m_tuser  = m_stat_q;

endmodule
